>>> src/forth_data_stack_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Forth data stack
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef FORTH_DATA_STACK_TOP_ASSERT_SVH
`define FORTH_DATA_STACK_TOP_ASSERT_SVH

// Same-cycle property.
`define FDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define FDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fds_pkg.sv
// ---------------------------------------------------------------------------
// fds_pkg
// Shared types and constants for the Forth data stack controller and datapath.
// ---------------------------------------------------------------------------
package fds_pkg;

  // Cells in the store; depth and capacity fields are 9 bits wide.
  localparam int STORE_CELLS = 256;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DUP   = 3'd3,
    OP_SWAP  = 3'd4,
    OP_OVER  = 3'd5,
    OP_ROT   = 3'd6,
    OP_CLEAR = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CAPT,
    S_THIRD,
    S_WR_A,
    S_WR_B,
    S_WR_C,
    S_FIN
  } state_t;

  // Write address, relative to the current depth.
  typedef enum logic [1:0] {
    WA_DEPTH,
    WA_MINUS1,
    WA_MINUS2,
    WA_MINUS3
  } wr_addr_sel_t;

  typedef enum logic [1:0] {
    WD_PUSH,
    WD_T0,
    WD_T1,
    WD_T2
  } wr_data_sel_t;

  typedef enum logic [1:0] {
    DEPTH_HOLD,
    DEPTH_INC,
    DEPTH_DEC,
    DEPTH_ZERO
  } depth_op_t;

  typedef struct packed {
    logic         load;       // latch push value
    logic         rd_en;      // read top and second
    logic         rd_third;   // read third on port 1
    logic         cap_top;    // capture top and second
    logic         cap_third;  // capture third
    logic         wr_en;
    wr_addr_sel_t wr_addr;
    wr_data_sel_t wr_data;
    logic         fin;        // load result register, update depth
    logic         refused;
    logic         take_top;
    depth_op_t    depth_op;
  } cmd_t;

  typedef struct packed {
    logic refuse;    // current input operation would be refused
    logic out_free;  // result register can take a new transaction
  } stat_t;

endpackage

>>> src/forth_data_stack_top.sv
// ---------------------------------------------------------------------------
// forth_data_stack_top
// Forth data stack of signed cells: push, pop, peek, dup, swap, over, rot,
// clear, with a capacity register and underflow/overflow refusal.
// ---------------------------------------------------------------------------
// Usage:
//  - Operation channel (op_valid/op_stall, operation, push_value): one
//    transaction per stack operation; op_stall is high while one is in progress.
//  - Result channel (res_valid/res_stall, status, top_value, depth_after):
//    one transaction per operation, in order. A stalled result stays put; the
//    next operation is accepted and runs until it must load its own result.
//  - Config: cfg_we/cfg_data write the capacity register (reset 256), idle only.
//  - Per operation: clear and refused operations go straight to the result
//    load; push writes, then loads; pop/peek read, capture, then load.
//    Dup/over/swap/rot also write each cell moved, rot reading a third first.
//    The cell memory has two registered read ports and one write port,
//    so each cell moved takes its own write.
//  - Reset (rst, synchronous) empties the stack and clears the result
//    valid flag; cell memory is not cleared, as no cell is read before written.
// ---------------------------------------------------------------------------
module forth_data_stack_top
  import fds_pkg::*;
#(
  parameter int CELL_WIDTH  = 64
) (
  input  logic               clk,
  input  logic               rst,
  // operation channel
  input  logic               op_valid,
  output logic               op_stall,
  input  logic [2:0]         operation,
  input  logic signed [63:0] push_value,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output logic               status,
  output logic signed [63:0] top_value,
  output logic [8:0]         depth_after,
  // capacity register
  input  logic               cfg_we,
  input  logic [8:0]         cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: decides refusal at accept, then walks reads/writes.
  fds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .operation (operation),
    .stat      (stat),
    .op_stall  (op_stall),
    .cmd       (cmd)
  );

  // Memory, depth/capacity and result register.
  fds_datapath #(
    .CELL_WIDTH  (CELL_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .operation   (operation),
    .push_value  (push_value),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .res_stall   (res_stall),
    .cmd         (cmd),
    .stat        (stat),
    .res_valid   (res_valid),
    .status      (status),
    .top_value   (top_value),
    .depth_after (depth_after)
  );

endmodule

>>> src/fds_ctrl.sv
// ---------------------------------------------------------------------------
// fds_ctrl
// Sequencer: steps each operation through reads, writes and result load.
// ---------------------------------------------------------------------------
module fds_ctrl
  import fds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       op_valid,
  input  logic [2:0] operation,
  input  stat_t      stat,
  output logic       op_stall,
  output cmd_t       cmd
);

  state_t state, state_next;
  op_t    op_q;
  logic   refused_q;
  logic   accept;

  assign op_stall = (state != S_IDLE);
  assign accept   = op_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op_q      <= OP_CLEAR;
      refused_q <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        op_q      <= op_t'(operation);
        refused_q <= stat.refuse;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat.refuse || op_t'(operation) == OP_CLEAR) state_next = S_FIN;
          else if (op_t'(operation) == OP_PUSH)            state_next = S_WR_A;
          else                                             state_next = S_READ;
        end
      end
      S_READ:  state_next = S_CAPT;
      S_CAPT: begin
        if (op_q == OP_ROT)                          state_next = S_THIRD;
        else if (op_q == OP_POP || op_q == OP_PEEK)  state_next = S_FIN;
        else                                         state_next = S_WR_A;
      end
      S_THIRD: state_next = S_WR_A;
      S_WR_A: begin
        if (op_q == OP_SWAP || op_q == OP_ROT) state_next = S_WR_B;
        else                                   state_next = S_FIN;
      end
      S_WR_B: begin
        if (op_q == OP_ROT) state_next = S_WR_C;
        else                state_next = S_FIN;
      end
      S_WR_C:  state_next = S_FIN;
      S_FIN: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.wr_addr  = WA_DEPTH;
    cmd.wr_data  = WD_PUSH;
    cmd.depth_op = DEPTH_HOLD;
    cmd.load     = accept;
    case (state)
      S_READ:  cmd.rd_en = 1'b1;
      S_CAPT: begin
        cmd.cap_top  = 1'b1;
        cmd.rd_third = (op_q == OP_ROT);
      end
      S_THIRD: cmd.cap_third = 1'b1;
      S_WR_A: begin
        cmd.wr_en = 1'b1;
        case (op_q)
          OP_DUP:  cmd.wr_data = WD_T0;
          OP_OVER: cmd.wr_data = WD_T1;
          OP_SWAP: begin
            cmd.wr_addr = WA_MINUS1;
            cmd.wr_data = WD_T1;
          end
          OP_ROT: begin
            cmd.wr_addr = WA_MINUS1;
            cmd.wr_data = WD_T2;
          end
          default: cmd.wr_data = WD_PUSH;
        endcase
      end
      S_WR_B: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = WA_MINUS2;
        cmd.wr_data = WD_T0;
      end
      S_WR_C: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = WA_MINUS3;
        cmd.wr_data = WD_T1;
      end
      S_FIN: begin
        cmd.fin      = stat.out_free;
        cmd.refused  = refused_q;
        cmd.take_top = !refused_q && (op_q == OP_POP || op_q == OP_PEEK);
        if (!refused_q) begin
          case (op_q)
            OP_PUSH, OP_DUP, OP_OVER: cmd.depth_op = DEPTH_INC;
            OP_POP:                   cmd.depth_op = DEPTH_DEC;
            OP_CLEAR:                 cmd.depth_op = DEPTH_ZERO;
            default:                  cmd.depth_op = DEPTH_HOLD;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/fds_datapath.sv
// ---------------------------------------------------------------------------
// fds_datapath
// Cell memory, depth and capacity registers, operand holding, result reg.
// ---------------------------------------------------------------------------
`include "forth_data_stack_top_assert.svh"

module fds_datapath
  import fds_pkg::*;
#(
  parameter int CELL_WIDTH  = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         operation,
  input  logic signed [63:0] push_value,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_data,
  input  logic               res_stall,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic               res_valid,
  output logic               status,
  output logic signed [63:0] top_value,
  output logic [8:0]         depth_after
);

  localparam int DW   = $clog2(STORE_CELLS + 1);
  localparam int AW   = $clog2(STORE_CELLS);
  localparam int CMPW = (DW > 9) ? DW : 9;

  logic [CELL_WIDTH-1:0] mem [STORE_CELLS];
  logic [CELL_WIDTH-1:0] rdata0, rdata1;
  logic [CELL_WIDTH-1:0] t0, t1, t2, pv, wdata;
  logic [DW-1:0]         depth, depth_next;
  logic [8:0]            capacity;
  logic [AW-1:0]         addr_m1, addr_m2, addr_m3, addr_d, raddr1, waddr;
  logic                  full, lt1, lt2, lt3;
  logic                  top_wr;

  // Full when depth reaches capacity, capacity saturating at the store size.
  assign full = (CMPW'(depth) >= CMPW'(capacity)) || (CMPW'(depth) >= CMPW'(STORE_CELLS));
  assign lt1  = (depth < DW'(1));
  assign lt2  = (depth < DW'(2));
  assign lt3  = (depth < DW'(3));

  always_comb begin
    stat.out_free = !res_valid || !res_stall;
    case (op_t'(operation))
      OP_PUSH:          stat.refuse = full;
      OP_POP, OP_PEEK:  stat.refuse = lt1;
      OP_DUP:           stat.refuse = lt1 || full;
      OP_SWAP:          stat.refuse = lt2;
      OP_OVER:          stat.refuse = lt2 || full;
      OP_ROT:           stat.refuse = lt3;
      default:          stat.refuse = 1'b0;
    endcase
  end

  assign addr_d  = AW'(depth);
  assign addr_m1 = AW'(depth - DW'(1));
  assign addr_m2 = AW'(depth - DW'(2));
  assign addr_m3 = AW'(depth - DW'(3));
  assign raddr1  = cmd.rd_third ? addr_m3 : addr_m2;
  assign top_wr  = cmd.wr_en && (cmd.wr_addr == WA_DEPTH);

  always_comb begin
    case (cmd.wr_addr)
      WA_MINUS1: waddr = addr_m1;
      WA_MINUS2: waddr = addr_m2;
      WA_MINUS3: waddr = addr_m3;
      default:   waddr = addr_d;
    endcase
    case (cmd.wr_data)
      WD_T0:   wdata = t0;
      WD_T1:   wdata = t1;
      WD_T2:   wdata = t2;
      default: wdata = pv;
    endcase
  end

  // Two registered read ports, one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata0 <= mem[addr_m1];
    if (cmd.rd_en || cmd.rd_third) rdata1 <= mem[raddr1];
    if (cmd.wr_en) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load)      pv <= push_value[CELL_WIDTH-1:0];
    if (cmd.cap_top) begin
      t0 <= rdata0;
      t1 <= rdata1;
    end
    if (cmd.cap_third) t2 <= rdata1;
  end

  always_comb begin
    case (cmd.depth_op)
      DEPTH_INC:  depth_next = depth + DW'(1);
      DEPTH_DEC:  depth_next = depth - DW'(1);
      DEPTH_ZERO: depth_next = '0;
      default:    depth_next = depth;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      capacity  <= 9'd256;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (cmd.fin) begin
        depth     <= depth_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      status      <= cmd.refused;
      top_value   <= cmd.take_top ? 64'($signed(t0)) : 64'sd0;
      depth_after <= 9'(depth_next);
    end
  end

  `FDS_ASSERT(a_depth_bound, depth <= DW'(STORE_CELLS), "depth above stack size")
  `FDS_ASSERT(a_fin_free, cmd.fin |-> (!res_valid || !res_stall), "result overwritten")
  `FDS_ASSERT_NEXT(a_refused_hold, cmd.fin && cmd.refused, $stable(depth), "refused op moved depth")
  `FDS_ASSERT(a_push_room, top_wr |-> (depth < DW'(STORE_CELLS)), "write past top of store")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: Forth data stack testbench
// Drives stack operations through a valid/stall channel, predicts every
// result with a shadow stack, and checks each result transaction in order.
// Covers underflow/overflow refusal, capacity changes and random traffic.
// ----------------------------------------------------------------------------
module tb;
  import fds_pkg::*;

  localparam int  NUM_CELLS   = STORE_CELLS;  // cells in the store
  localparam int  RUN_LIMIT   = 400000;  // cycles before declaring a hang
  localparam bit  ST_DONE     = 1'b0;
  localparam bit  ST_REFUSED  = 1'b1;
  localparam logic [63:0] CELL_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] CELL_MIN = 64'h8000_0000_0000_0000;

  // one pending stack operation
  typedef struct {
    op_t         op;
    logic [63:0] val;
  } stack_cmd_t;

  // one result transaction as the block should return it
  typedef struct {
    logic        status;
    logic [63:0] top;
    logic [8:0]  depth;
  } stack_result_t;

  // DUT ports - every input known from time zero
  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               op_valid   = 1'b0;
  logic               op_stall;
  logic [2:0]         operation  = 3'd0;
  logic signed [63:0] push_value = 64'sd0;
  logic               res_valid;
  logic               res_stall  = 1'b0;
  logic               status;
  logic signed [63:0] top_value;
  logic [8:0]         depth_after;
  logic               cfg_we     = 1'b0;
  logic [8:0]         cfg_data   = 9'd0;

  // stimulus and scoreboard
  stack_cmd_t    op_queue[$];          // filled by the sequence, drained by the driver
  stack_result_t expected_results[$];  // one entry per accepted operation
  stack_cmd_t    next_cmd;
  stack_result_t want;
  int            pending_ops   = 0;    // queued but not yet accepted
  int            err_cnt       = 0;
  int            cycle_cnt     = 0;
  int            snd_idle_pct  = 0;    // sender gap probability, percent
  int            rcv_stall_pct = 0;    // receiver stall probability, percent

  // shadow copy of the stack state
  logic [63:0]   shadow_cells[NUM_CELLS];
  logic [8:0]    shadow_depth = 9'd0;
  logic [8:0]    shadow_cap   = 9'd256;

  forth_data_stack_top dut (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (op_valid),
    .op_stall    (op_stall),
    .operation   (operation),
    .push_value  (push_value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .top_value   (top_value),
    .depth_after (depth_after),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Address of the cell k places below the top, kept to its low 8 bits,
  // matching a store of exactly NUM_CELLS entries.
  function automatic logic [7:0] cell_idx(input int k);
    logic [8:0] a;
    a = shadow_depth - 9'd1 - k[8:0];
    return a[7:0];
  endfunction

  // Apply one accepted operation to the shadow stack and queue its result.
  task automatic apply_stack_op(input op_t op, input logic [63:0] val);
    stack_result_t r;
    int            eff_cap;
    bit            full;
    logic [63:0]   a, b, c;
    eff_cap  = (shadow_cap > NUM_CELLS) ? NUM_CELLS : shadow_cap;  // saturates
    full     = (shadow_depth >= eff_cap);  // zero capacity: always full
    r.status = ST_DONE;
    r.top    = '0;
    case (op)
      OP_PUSH: begin
        if (full) r.status = ST_REFUSED;
        else begin
          shadow_cells[shadow_depth[7:0]] = val;
          shadow_depth++;
        end
      end
      OP_POP: begin
        if (shadow_depth < 1) r.status = ST_REFUSED;
        else begin
          r.top = shadow_cells[cell_idx(0)];
          shadow_depth--;
        end
      end
      OP_PEEK: begin
        if (shadow_depth < 1) r.status = ST_REFUSED;
        else r.top = shadow_cells[cell_idx(0)];
      end
      OP_DUP: begin
        if (shadow_depth < 1 || full) r.status = ST_REFUSED;
        else begin
          a = shadow_cells[cell_idx(0)];
          shadow_cells[shadow_depth[7:0]] = a;
          shadow_depth++;
        end
      end
      OP_SWAP: begin
        if (shadow_depth < 2) r.status = ST_REFUSED;
        else begin
          a = shadow_cells[cell_idx(0)];
          b = shadow_cells[cell_idx(1)];
          shadow_cells[cell_idx(0)] = b;
          shadow_cells[cell_idx(1)] = a;
        end
      end
      OP_OVER: begin
        if (shadow_depth < 2 || full) r.status = ST_REFUSED;
        else begin
          a = shadow_cells[cell_idx(1)];
          shadow_cells[shadow_depth[7:0]] = a;
          shadow_depth++;
        end
      end
      OP_ROT: begin
        // ( a b c -- b c a ), c on top
        if (shadow_depth < 3) r.status = ST_REFUSED;
        else begin
          a = shadow_cells[cell_idx(2)];
          b = shadow_cells[cell_idx(1)];
          c = shadow_cells[cell_idx(0)];
          shadow_cells[cell_idx(2)] = b;
          shadow_cells[cell_idx(1)] = c;
          shadow_cells[cell_idx(0)] = a;
        end
      end
      default: shadow_depth = '0;  // clear always succeeds
    endcase
    r.depth = shadow_depth;
    expected_results.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued operations. Payload holds while stalled; a new
  // transaction (or a gap) is chosen only once the current one is accepted.
  // The accepted transaction is predicted at the same edge, in this block, so
  // pending_ops and expected_results change together.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      if (op_valid && !op_stall) begin
        apply_stack_op(op_t'(operation), push_value);
        pending_ops--;
      end
      if (!op_valid || !op_stall) begin
        if (op_queue.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          next_cmd   = op_queue.pop_front();
          op_valid   <= 1'b1;
          operation  <= next_cmd.op;
          push_value <= next_cmd.val;
        end else begin
          op_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random stall on the result side, then compare each accepted
  // result transaction against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status=%0b top=%0d depth=%0d",
                 status, top_value, depth_after);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, status);
            err_cnt++;
          end
          if (top_value !== want.top) begin
            $error("top_value: expected %0d, got %0d", $signed(want.top), top_value);
            err_cnt++;
          end
          if (depth_after !== want.depth) begin
            $error("depth_after: expected %0d, got %0d", want.depth, depth_after);
            err_cnt++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  task automatic queue_op(input op_t op, input logic [63:0] val);
    stack_cmd_t c;
    c.op  = op;
    c.val = val;
    op_queue.push_back(c);
    pending_ops++;
  endtask

  // All transactions accepted and answered, then a short settle.
  task automatic wait_drained();
    while (pending_ops != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity write: only called while the block is idle.
  task automatic write_capacity(input logic [8:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    shadow_cap = v;
  endtask

  // Mix of small, extreme and fully random cell values.
  function automatic logic [63:0] rand_cell();
    case ($urandom_range(0, 5))
      0:       return CELL_MAX;
      1:       return CELL_MIN;
      2:       return 64'($urandom_range(0, 15));
      3:       return ~64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // push_w percent pushes, clear_w percent clears, the rest spread over the
  // six other operations.
  function automatic op_t pick_op(input int push_w, input int clear_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_w) return OP_PUSH;
    if (r < push_w + clear_w) return OP_CLEAR;
    return op_t'($urandom_range(int'(OP_POP), int'(OP_ROT)));
  endfunction

  task automatic run_random(input int n, input int push_w, input int clear_w);
    op_t op;
    repeat (n) begin
      op = pick_op(push_w, clear_w);
      queue_op(op, (op == OP_PUSH) ? rand_cell() : {$urandom, $urandom});
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // sender idles 32%, receiver stalls 67%
    snd_idle_pct  = 32;
    rcv_stall_pct = 67;

    write_capacity(9'd256);

    // empty stack: every read-type op underflows, clear still succeeds
    queue_op(OP_POP,   '0);
    queue_op(OP_PEEK,  '0);
    queue_op(OP_DUP,   '0);
    queue_op(OP_SWAP,  '0);
    queue_op(OP_OVER,  '0);
    queue_op(OP_ROT,   '0);
    queue_op(OP_CLEAR, '0);
    // one and two cells: swap/over then rot still too shallow
    queue_op(OP_PUSH,  CELL_MAX);
    queue_op(OP_SWAP,  '0);
    queue_op(OP_OVER,  '0);
    queue_op(OP_PUSH,  CELL_MIN);
    queue_op(OP_ROT,   '0);
    queue_op(OP_PUSH,  64'd0);
    queue_op(OP_PUSH,  64'hffff_ffff_ffff_ffff);
    // the full set on a healthy stack
    queue_op(OP_PEEK,  '0);
    queue_op(OP_DUP,   '0);
    queue_op(OP_OVER,  '0);
    queue_op(OP_SWAP,  '0);
    queue_op(OP_ROT,   '0);
    queue_op(OP_POP,   '0);
    wait_drained();

    // capacity dropped below the depth: growth refused, the rest still works
    write_capacity(9'd2);
    queue_op(OP_PUSH, CELL_MAX);
    queue_op(OP_DUP,  '0);
    queue_op(OP_OVER, '0);
    queue_op(OP_SWAP, '0);
    queue_op(OP_ROT,  '0);
    queue_op(OP_POP,  '0);
    wait_drained();

    // tiny capacities: refusals at both ends are frequent
    write_capacity(9'd3);
    run_random(150, 20, 4);
    wait_drained();
    write_capacity(9'd1);
    run_random(100, 20, 4);
    wait_drained();

    // sender idles 67%, receiver stalls 32%
    snd_idle_pct  = 67;
    rcv_stall_pct = 32;

    // capacity above the store saturates; push-heavy, no clear, to fill all
    // 256 cells and keep hitting the full stack
    write_capacity(9'd511);
    run_random(500, 60, 0);
    wait_drained();

    // no idling from here on
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;

    // zero capacity with a deep stack: every push/dup/over refused
    write_capacity(9'd0);
    run_random(60, 25, 2);
    wait_drained();

    // a random mid-range capacity
    write_capacity(9'($urandom_range(2, 40)));
    run_random(250, 30, 3);
    wait_drained();

    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: done, errors");
    $finish;
  end

endmodule
